@@ design/psu_pkg.sv @@
// Shared types, codes and the Paeth predictor for the PNG scanline unfilter.
package psu_pkg;

  // Register indexes on the configuration port (byte address 4 * index).
  localparam int unsigned CfgAddrW = 3;
  localparam logic REG_BPP       = 1'b0;
  localparam logic REG_ROW_BYTES = 1'b1;

  localparam logic [3:0]  BPP_RESET       = 4'd1;
  localparam logic [13:0] ROW_BYTES_RESET = 14'd1;

  // Decoded filter of a row. Codes above Paeth are collapsed into FILT_BAD.
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4,
    FILT_BAD   = 3'd5
  } filt_e;

  typedef struct packed {
    logic [3:0]  bpp;
    logic [13:0] row_bytes;
  } psu_cfg_t;

  // One data byte on its way from the fetch stage to reconstruction.
  typedef struct packed {
    logic [7:0] x;       // filtered byte
    filt_e      filt;    // filter of the row it belongs to
    logic       last;    // final byte of the row
    logic       clear;   // first byte of a row: left neighbours are zero
    logic       b_zero;  // first row of an image: bytes above are zero
  } psu_item_t;

  function automatic filt_e decode_filter(input logic [7:0] code);
    filt_e f;
    if (code > 8'd4) begin
      f = FILT_BAD;
    end else begin
      f = filt_e'(code[2:0]);
    end
    return f;
  endfunction

  function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [10:0] p;
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    logic [7:0]         res;
    p  = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
    da = p - $signed({3'b000, a});
    db = p - $signed({3'b000, b});
    dc = p - $signed({3'b000, c});
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if ((da <= db) && (da <= dc)) begin
      res = a;
    end else if (db <= dc) begin
      res = b;
    end else begin
      res = c;
    end
    return res;
  endfunction

endpackage

@@ design/psu_in_if.sv @@
// Input stream channel: one inflated byte per item.
interface psu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_image;

  modport source (output valid, output in_byte, output start_image, input ready);
  modport sink (input valid, input in_byte, input start_image, output ready);
endinterface

@@ design/psu_out_if.sv @@
// Output stream channel: one reconstructed byte per item.
interface psu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_row;
  logic       bad_filter;

  modport source (output valid, output out_byte, output last_of_row, output bad_filter,
                  input ready);
  modport sink (input valid, input out_byte, input last_of_row, input bad_filter,
                output ready);
endinterface

@@ design/png_scanline_unfilter_top.sv @@
// Top level of the PNG scanline unfilter: row control, line buffer and reconstruction.
//
//  Channel  Direction  Handshake        Payload
//  in_if    sink       valid / ready    in_byte[7:0], start_image
//  out_if   source     valid / ready    out_byte[7:0], last_of_row, bad_filter
//  APB      slave      psel / penable   paddr, pwdata, prdata (pready tied high)
//
// The block takes one item per clock cycle while the output is not stalled. A data byte
// reads the line buffer in the cycle it is accepted and waits in the fetch stage for the
// read data; it is then reconstructed and, once taken, held in the output register.
// The registered read of the line buffer and the left-neighbour loop through the
// reconstruction stage shape this pipeline; filter bytes are consumed by the row control
// and give no result. Reset is asynchronous and clears all control state at once; the
// line buffer is not cleared, since every entry is written by a row before the next
// row reads it. When the output is stalled the reconstruction stage holds its item and
// the input stalls behind it, so no item is lost or repeated.
module png_scanline_unfilter_top
  import psu_pkg::*;
#(
  parameter int unsigned MAX_ROW_BYTES   = 8192,
  parameter int unsigned MAX_PIXEL_BYTES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  psu_in_if.sink              in_if,
  psu_out_if.source           out_if
);

  localparam int unsigned ColW = $clog2(MAX_ROW_BYTES);
  localparam int unsigned LenW = (ColW + 1 > 14) ? ColW + 1 : 14;
  localparam int unsigned SelW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  psu_cfg_t  cfg;

  // Row control state.
  logic [ColW-1:0] column_q, column_d;
  filt_e           row_filt_q, row_filt_d;
  logic            first_row_q, first_row_d;
  logic            expect_q, expect_d;

  // Fetch stage holding a data item while its line-buffer read completes.
  logic            s1_valid_q;
  psu_item_t       s1_item_q;
  logic [ColW-1:0] s1_addr_q;

  logic            accept;
  logic            is_filter;
  logic            data_acc;
  logic            first_eff;
  logic            row_last;
  logic [LenW-1:0] rb_ext;
  logic [LenW-1:0] row_len;
  logic [3:0]      bpp_m1;
  logic [SelW-1:0] bpp_sel;
  logic            take;
  logic [7:0]      recon;
  logic [7:0]      above;

  psu_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Out-of-range register values are clamped: zero counts as one, and values above
  // the built-in maxima count as the maxima.
  always_comb begin
    bpp_m1 = (cfg.bpp == 4'd0) ? 4'd0 : cfg.bpp - 4'd1;
    if (bpp_m1 > 4'(MAX_PIXEL_BYTES - 1)) begin
      bpp_m1 = 4'(MAX_PIXEL_BYTES - 1);
    end
    rb_ext = LenW'(cfg.row_bytes);
    if (rb_ext == '0) begin
      row_len = LenW'(1);
    end else if (rb_ext > LenW'(MAX_ROW_BYTES)) begin
      row_len = LenW'(MAX_ROW_BYTES);
    end else begin
      row_len = rb_ext;
    end
  end

  assign bpp_sel = bpp_m1[SelW-1:0];

  // A new item enters whenever the fetch stage is empty or hands its item on.
  assign in_if.ready = ~s1_valid_q | take;
  assign accept      = in_if.valid & in_if.ready;

  // A start-of-image byte is always a filter byte, and it opens a first row.
  assign is_filter = in_if.start_image | expect_q;
  assign first_eff = in_if.start_image | first_row_q;
  assign data_acc  = accept & ~is_filter;
  assign row_last  = (LenW'(column_q) + LenW'(1)) >= row_len;

  always_comb begin
    column_d    = column_q;
    row_filt_d  = row_filt_q;
    first_row_d = first_row_q;
    expect_d    = expect_q;
    if (accept) begin
      if (is_filter) begin
        row_filt_d  = decode_filter(in_if.in_byte);
        column_d    = '0;
        expect_d    = 1'b0;
        first_row_d = first_eff;
      end else if (row_last) begin
        column_d    = '0;
        expect_d    = 1'b1;
        first_row_d = 1'b0;
      end else begin
        column_d    = column_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q    <= '0;
      row_filt_q  <= FILT_NONE;
      first_row_q <= 1'b1;
      expect_q    <= 1'b1;
      s1_valid_q  <= 1'b0;
    end else begin
      column_q    <= column_d;
      row_filt_q  <= row_filt_d;
      first_row_q <= first_row_d;
      expect_q    <= expect_d;
      if (data_acc) begin
        s1_valid_q <= 1'b1;
      end else if (take) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_acc) begin
      s1_item_q.x      <= in_if.in_byte;
      s1_item_q.filt   <= row_filt_q;
      s1_item_q.last   <= row_last;
      s1_item_q.clear  <= (column_q == '0);
      s1_item_q.b_zero <= first_eff;
      s1_addr_q        <= column_q;
    end
  end

  // Line buffer of the previous row. The reconstructed byte is written back at the
  // column it was read from. A read and a write of the same column are always at
  // least one filter byte apart, and an item is only accepted when the fetch stage
  // drains, so the write lands before the next row reads that column.
  psu_ram #(
    .Width (8),
    .Depth (MAX_ROW_BYTES)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (take),
    .waddr_i (s1_addr_q),
    .wdata_i (recon),
    .re_i    (data_acc),
    .raddr_i (column_q),
    .rdata_o (above)
  );

  psu_recon #(
    .MaxPix (MAX_PIXEL_BYTES)
  ) u_recon (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s1_valid_q),
    .item_i       (s1_item_q),
    .above_i      (above),
    .bpp_sel_i    (bpp_sel),
    .take_o       (take),
    .recon_o      (recon),
    .out_if       (out_if)
  );

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && data_acc) |-> (s1_addr_q != column_q))
    else $error("line buffer read and write hit the same column");

  a_idle_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    expect_q |-> (column_q == '0))
    else $error("column not cleared while waiting for a filter byte");

  a_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (data_acc && row_last) |=> (expect_q && !first_row_q))
    else $error("row end did not arm the next filter byte");

endmodule

@@ design/psu_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module psu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/psu_cfg.sv @@
// APB-style configuration registers: bytes per pixel and row length.
module psu_cfg
  import psu_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output psu_cfg_t            cfg_o
);

  psu_cfg_t cfg_q;
  logic     wr_en;
  logic     reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bpp       <= BPP_RESET;
      cfg_q.row_bytes <= ROW_BYTES_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BPP:       cfg_q.bpp       <= pwdata[3:0];
        REG_ROW_BYTES: cfg_q.row_bytes <= pwdata[13:0];
        default:       cfg_q           <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BPP:       prdata = {28'd0, cfg_q.bpp};
      REG_ROW_BYTES: prdata = {18'd0, cfg_q.row_bytes};
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/psu_recon.sv @@
// Reconstruction stage: neighbour history, filter inversion and output register.
module psu_recon
  import psu_pkg::*;
#(
  parameter int unsigned MaxPix = 8,
  localparam int unsigned SelW  = (MaxPix > 1) ? $clog2(MaxPix) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  input  psu_item_t       item_i,
  input  logic [7:0]      above_i,
  input  logic [SelW-1:0] bpp_sel_i,
  output logic            take_o,
  output logic [7:0]      recon_o,
  psu_out_if.source       out_if
);

  logic [7:0] left_q [MaxPix];
  logic [7:0] left_d [MaxPix];
  logic [7:0] upl_q  [MaxPix];
  logic [7:0] upl_d  [MaxPix];

  logic [7:0] a_byte;
  logic [7:0] b_byte;
  logic [7:0] c_byte;
  logic [7:0] pred;
  logic [8:0] avg_sum;
  logic [7:0] recon;
  logic       take;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       out_bad_q;

  // The item moves on whenever the output register is empty or being drained.
  assign take = item_valid_i & (~out_valid_q | out_if.ready);

  assign a_byte  = item_i.clear  ? 8'd0 : left_q[bpp_sel_i];
  assign c_byte  = item_i.clear  ? 8'd0 : upl_q[bpp_sel_i];
  assign b_byte  = item_i.b_zero ? 8'd0 : above_i;
  assign avg_sum = {1'b0, a_byte} + {1'b0, b_byte};

  always_comb begin
    case (item_i.filt)
      FILT_SUB:   pred = a_byte;
      FILT_UP:    pred = b_byte;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = paeth_pred(a_byte, b_byte, c_byte);
      default:    pred = 8'd0;
    endcase
  end

  assign recon = item_i.x + pred;

  // The newest byte enters at index 0. The first byte of a row starts from zeros.
  always_comb begin
    left_d[0] = recon;
    upl_d[0]  = b_byte;
    for (int i = 1; i < MaxPix; i++) begin
      left_d[i] = item_i.clear ? 8'd0 : left_q[i-1];
      upl_d[i]  = item_i.clear ? 8'd0 : upl_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxPix; i++) begin
        left_q[i] <= 8'd0;
        upl_q[i]  <= 8'd0;
      end
    end else if (take) begin
      left_q <= left_d;
      upl_q  <= upl_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_byte_q <= recon;
      out_last_q <= item_i.last;
      out_bad_q  <= (item_i.filt == FILT_BAD);
    end
  end

  assign take_o             = take;
  assign recon_o            = recon;
  assign out_if.valid       = out_valid_q;
  assign out_if.out_byte    = out_byte_q;
  assign out_if.last_of_row = out_last_q;
  assign out_if.bad_filter  = out_bad_q;

  a_rose_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(item_valid_i))
    else $error("result appeared without an item in reconstruction");

  a_no_take_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_if.ready) |-> !take)
    else $error("result register overwritten while stalled");

endmodule

@@ dv/tb_png_scanline_unfilter_top.sv @@
// Self-checking testbench for the PNG scanline unfilter: random streams, stalls and a predictor.
module tb_png_scanline_unfilter_top;
  import psu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The block is built with its default sizes; the predictor mirrors them.
  localparam int unsigned MaxRow = 8192;
  localparam int unsigned MaxPix = 8;

  // Cycles without any accepted item before the run is declared hung. The longest
  // legal quiet stretch is the receiver's long hold-off plus a register update.
  localparam int unsigned QuietLimit = 1000;

  // The receiver stops taking results for this many cycles once, after this many
  // results, so that the block fills up and pushes back on its input.
  localparam int unsigned HoldAfter  = 300;
  localparam int unsigned HoldCycles = 150;

  // Settle time after the last expected result before a register write or the
  // final verdict.
  localparam int unsigned SettleCycles = 8;

  // Items on each random phase before the next register setting is applied.
  localparam int unsigned PhaseItems = 55;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_image;
  } stream_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_row;
    logic       bad_filter;
  } recon_t;

  logic clk_i;
  logic rst_ni;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  psu_in_if  in_if ();
  psu_out_if out_if ();

  png_scanline_unfilter_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_if   (in_if),
    .out_if  (out_if)
  );

  // Stream bytes waiting for the driver, and reconstructed bytes still owed by the block.
  stream_item_t byte_q[$];
  recon_t       recon_q[$];

  int unsigned n_queued;   // bytes handed to the driver so far
  int unsigned n_taken;    // bytes the block has accepted
  int unsigned n_errors;

  // Register copies, updated at the write itself.
  logic [3:0]  cfg_bpp;
  logic [13:0] cfg_row_bytes;

  // Predictor state: the reconstructed previous row, the last eight reconstructed
  // bytes and the last eight bytes above (newest in the low byte), and row control.
  logic [7:0]  line_mem [MaxRow];
  logic [63:0] left_hist;
  logic [63:0] upleft_hist;
  int unsigned col;
  filt_e       row_filt;
  logic        line_first;
  logic        want_filter;

  // Clock; reset is held low from time zero and released by the stimulus process.
  initial begin
    clk_i  = 1'b0;
    rst_ni = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Every input of the block is known from the very first instant.
  initial begin
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_if.valid          = 1'b0;
    in_if.in_byte        = '0;
    in_if.start_image    = 1'b0;
    out_if.ready         = 1'b0;
  end

  // Out-of-range register values are clamped by the block, not rejected.
  function automatic int unsigned pixel_span(input logic [3:0] v);
    int unsigned n;
    n = v;
    if (n < 1) n = 1;
    if (n > MaxPix) n = MaxPix;
    return n;
  endfunction

  function automatic int unsigned line_len(input logic [13:0] v);
    int unsigned n;
    n = v;
    if (n < 1) n = 1;
    if (n > MaxRow) n = MaxRow;
    return n;
  endfunction

  // Paeth picks whichever of left, above and upper-left is nearest to a + b - c,
  // with ties resolved in that order.
  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    int p;
    int pa;
    int pb;
    int pc;
    p  = int'(a) + int'(b) - int'(c);
    pa = (p > int'(a)) ? p - int'(a) : int'(a) - p;
    pb = (p > int'(b)) ? p - int'(b) : int'(b) - p;
    pc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
    if (pa <= pb && pa <= pc) return a;
    if (pb <= pc) return b;
    return c;
  endfunction

  // Runs one accepted stream byte through the predictor. A filter byte only sets up
  // the row; a data byte queues the reconstructed byte the block must deliver.
  function automatic void unfilter_step(input stream_item_t it);
    int unsigned shift;
    int unsigned idx;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  pred;
    logic [7:0]  r;
    logic        last;
    recon_t      res;
    if (it.start_image) begin
      line_first  = 1'b1;
      want_filter = 1'b1;
    end
    if (want_filter) begin
      // Codes above Paeth decode as None but are flagged on every byte of the row.
      row_filt    = (it.in_byte > 8'd4) ? FILT_BAD : filt_e'(it.in_byte[2:0]);
      col         = 0;
      left_hist   = '0;
      upleft_hist = '0;
      want_filter = 1'b0;
      return;
    end
    shift = (pixel_span(cfg_bpp) - 1) * 8;
    idx   = (col < MaxRow) ? col : MaxRow - 1;
    a     = left_hist[shift +: 8];
    c     = upleft_hist[shift +: 8];
    b     = line_first ? 8'd0 : line_mem[idx];
    case (row_filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = 8'((9'(a) + 9'(b)) >> 1);
      FILT_PAETH: pred = paeth_pick(a, b, c);
      default:    pred = 8'd0;
    endcase
    r             = it.in_byte + pred;
    line_mem[idx] = r;
    left_hist     = {left_hist[55:0], r};
    upleft_hist   = {upleft_hist[55:0], b};
    last          = (col + 1) >= line_len(cfg_row_bytes);
    if (last) begin
      col         = 0;
      want_filter = 1'b1;
      line_first  = 1'b0;
    end else begin
      col = (col + 1) & 32'h3FFF;
    end
    res.out_byte    = r;
    res.last_of_row = last;
    res.bad_filter  = (row_filt == FILT_BAD);
    recon_q.insert(recon_q.size(), res);
  endfunction

  task automatic queue_item(input logic [7:0] v, input logic start);
    stream_item_t it;
    it.in_byte     = v;
    it.start_image = start;
    byte_q.insert(byte_q.size(), it);
    n_queued++;
  endtask

  // Mostly the five real filters, about one row in ten an unknown code.
  function automatic logic [7:0] pick_filter();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(5, 255));
    return 8'($urandom_range(0, 4));
  endfunction

  // Random data with extra weight on the two extremes, where wrap-around happens.
  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One image of well-formed rows with random content. Now and then the last row is
  // cut short, so the next image's start byte lands in the middle of a row.
  task automatic queue_image();
    int unsigned len;
    int unsigned rows;
    int unsigned keep;
    len  = line_len(cfg_row_bytes);
    rows = $urandom_range(1, (len > 20) ? 2 : 5);
    for (int unsigned r = 0; r < rows; r++) begin
      queue_item(pick_filter(), r == 0);
      keep = len;
      if (r == rows - 1 && $urandom_range(0, 9) == 0) keep = $urandom_range(0, len - 1);
      for (int unsigned k = 0; k < keep; k++) queue_item(pick_data(), 1'b0);
    end
  endtask

  // Waits until every queued byte is in and every expected result is out, then lets
  // the pipeline drain, since a filter byte may still be in flight with nothing owed.
  task automatic wait_idle();
    while (n_taken != n_queued || recon_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle; the register takes the value at the
  // edge where psel, penable and pready are all high. Unused upper bits are random
  // to show that the block keeps only the register's own width.
  task automatic cfg_write(input logic sel, input int unsigned v);
    logic [31:0] word;
    logic [31:0] mask;
    mask = (sel == REG_BPP) ? 32'h0000_000F : 32'h0000_3FFF;
    word = ($urandom() & ~mask) | (v & mask);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAddrW'({sel, 2'b00});
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_BPP) begin
      cfg_bpp = word[3:0];
    end else begin
      cfg_row_bytes = word[13:0];
    end
  endtask

  // Input driver. The predictor runs at the edge where a byte is accepted, so it
  // always sees the register values that the block sees. The driver inserts idle gaps
  // between items, and now and then it switches to back-to-back mode.
  stream_item_t in_cur;
  int unsigned  in_wait;
  logic         in_calm;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_wait = 0;
      in_calm = 1'b0;
    end else begin
      if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
        n_taken++;
        unfilter_step(in_cur);
      end
      if (in_if.valid !== 1'b1 || in_if.ready === 1'b1) begin
        if (in_wait > 0) begin
          in_wait--;
          in_if.valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          in_cur = byte_q.pop_front();
          in_if.in_byte     <= in_cur.in_byte;
          in_if.start_image <= in_cur.start_image;
          in_if.valid       <= 1'b1;
          if ($urandom_range(0, 39) == 0) in_calm = ~in_calm;
          in_wait = in_calm ? 0 : $urandom_range(0, 5);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. It stalls at random after each result, with stall-free stretches,
  // and once holds off for a long stretch while the driver keeps offering bytes.
  int unsigned n_drained;
  int unsigned out_wait;
  int unsigned hold_left;
  logic        out_calm;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      n_drained = 0;
      out_wait  = 0;
      hold_left = 0;
      out_calm  = 1'b0;
    end else begin
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        n_drained++;
        if (n_drained == HoldAfter) begin
          hold_left = HoldCycles;
        end else begin
          if ($urandom_range(0, 39) == 0) out_calm = ~out_calm;
          out_wait = out_calm ? 0 : $urandom_range(0, 5);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Result checker: each delivered byte is matched against the oldest expectation.
  recon_t want;

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (recon_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result: expected none, actual out_byte %h last %b bad %b",
                 $time, out_if.out_byte, out_if.last_of_row, out_if.bad_filter);
      end else begin
        want = recon_q.pop_front();
        if (out_if.out_byte !== want.out_byte) begin
          n_errors++;
          $display("%0t: out_byte mismatch: expected %h, actual %h",
                   $time, want.out_byte, out_if.out_byte);
        end
        if (out_if.last_of_row !== want.last_of_row) begin
          n_errors++;
          $display("%0t: last_of_row mismatch: expected %b, actual %b",
                   $time, want.last_of_row, out_if.last_of_row);
        end
        if (out_if.bad_filter !== want.bad_filter) begin
          n_errors++;
          $display("%0t: bad_filter mismatch: expected %b, actual %b",
                   $time, want.bad_filter, out_if.bad_filter);
        end
      end
    end
  end

  // Watchdog: a hung handshake on either side ends the run.
  int unsigned quiet;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet = 0;
    end else if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
                 (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QuietLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, QuietLimit);
        $display("tb_png_scanline_unfilter_top: errors");
        $finish;
      end
    end
  end

  // Stimulus: a directed part covering each filter, the extremes of the byte, an
  // unknown filter code, a restart in mid-row and register changes in mid-row; then
  // random phases over many register settings, including out-of-range values.
  int unsigned ph_bpp [17] = '{1, 0, 8, 15, 2, 3, 4, 5, 6, 7, 9, 8, 1, 0, 0, 0, 0};
  int unsigned ph_len [17] = '{1, 0, 3, 5, 16, 9, 20, 11, 30, 7, 12, 64, 2, 0, 0, 0, 0};
  int unsigned phase_base;

  initial begin
    n_queued    = 0;
    n_taken     = 0;
    n_errors    = 0;
    cfg_bpp     = BPP_RESET;
    cfg_row_bytes = ROW_BYTES_RESET;
    left_hist   = '0;
    upleft_hist = '0;
    col         = 0;
    row_filt    = FILT_NONE;
    line_first  = 1'b1;
    want_filter = 1'b1;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    cfg_write(REG_BPP, 1);
    cfg_write(REG_ROW_BYTES, 2);

    // One row per filter type; the zero filter after Paeth must not reuse Paeth.
    queue_item(8'd0, 1'b1);  queue_item(8'h00, 1'b0); queue_item(8'hFF, 1'b0);
    queue_item(8'd1, 1'b0);  queue_item(8'h80, 1'b0); queue_item(8'hFF, 1'b0);
    queue_item(8'd2, 1'b0);  queue_item(8'h01, 1'b0); queue_item(8'hFF, 1'b0);
    queue_item(8'd3, 1'b0);  queue_item(8'hFF, 1'b0); queue_item(8'h80, 1'b0);
    queue_item(8'd4, 1'b0);  queue_item(8'h7F, 1'b0); queue_item(8'h01, 1'b0);
    queue_item(8'd0, 1'b0);  queue_item(8'h55, 1'b0); queue_item(8'hAA, 1'b0);
    // Unknown filter code: decoded as None and flagged.
    queue_item(8'hFF, 1'b0); queue_item(8'h00, 1'b0); queue_item(8'hFF, 1'b0);
    // A new image starts in the middle of a row; the partial row is left unfinished.
    queue_item(8'd4, 1'b1);  queue_item(8'h10, 1'b0);
    queue_item(8'd3, 1'b1);  queue_item(8'h20, 1'b0);
    // Row length shrinks so the current column lies beyond the row end: the next byte ends the row.
    wait_idle();
    cfg_write(REG_ROW_BYTES, 1);
    queue_item(8'h30, 1'b0);
    // Pixel width changes after the filter byte, before the row's data.
    queue_item(8'd1, 1'b0);
    wait_idle();
    cfg_write(REG_BPP, 2);
    queue_item(8'h40, 1'b0);

    for (int unsigned ph = 0; ph < 17; ph++) begin
      wait_idle();
      if (ph >= 13) begin
        cfg_write(REG_ROW_BYTES, $urandom_range(0, 40));
        cfg_write(REG_BPP, $urandom_range(0, 15));
      end else begin
        cfg_write(REG_BPP, ph_bpp[ph]);
        cfg_write(REG_ROW_BYTES, ph_len[ph]);
      end
      // Every phase opens a new image, so a longer row never reads a column
      // of the line buffer that no earlier row of the image has written.
      phase_base = n_queued;
      while (n_queued - phase_base < PhaseItems) queue_image();
    end

    wait_idle();
    if (n_errors == 0 && recon_q.size() == 0) begin
      $display("tb_png_scanline_unfilter_top: clean");
    end else begin
      $display("tb_png_scanline_unfilter_top: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/psu_pkg.sv
design/psu_in_if.sv
design/psu_out_if.sv
design/psu_ram.sv
design/psu_cfg.sv
design/psu_recon.sv
design/png_scanline_unfilter_top.sv
dv/tb_png_scanline_unfilter_top.sv
